[design/alpmf_pkg.sv]
// shared constants, codes, types and helpers of the angle low-pass / median filter
package alpmf_pkg;

  localparam int MAX_WINDOW = 19;

  localparam int RawW      = 12;
  localparam int FracW     = 12;
  localparam int OutW      = RawW + FracW;
  localparam int AlphaW    = 16;
  localparam int AlphaFrac = 15;
  localparam int WinW      = 6;
  localparam int ThrW      = 12;
  localparam int ModeW     = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int RingAw    = $clog2(MAX_WINDOW);

  // filter modes
  localparam logic [ModeW-1:0] ModePass    = 2'd0;
  localparam logic [ModeW-1:0] ModeLowpass = 2'd1;
  localparam logic [ModeW-1:0] ModeMedian  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAlpha  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWindow = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgThresh = 2'd3;

  // reset values
  localparam logic [AlphaFrac:0] AlphaOne = {1'b1, {AlphaFrac{1'b0}}};
  localparam logic [AlphaW-1:0]  AlphaRst = AlphaW'(AlphaOne);
  localparam logic [WinW-1:0]    WinRst   = WinW'(1);
  localparam logic [ThrW-1:0]    ThrRst   = ThrW'(2048);

  typedef struct packed {
    logic            start;
    logic [RawW-1:0] raw;
  } filt_req_t;

  typedef struct packed {
    logic            done;
    logic [OutW-1:0] value;
  } filt_rsp_t;

  function automatic logic [OutW-1:0] to_q12(logic [RawW-1:0] raw);
    return {raw, {FracW{1'b0}}};
  endfunction

endpackage

[design/alpmf_ring.sv]
// sample ring memory: one write port, two registered read ports, per-entry valid bits
module alpmf_ring (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clr_i,
  input  logic                           we_i,
  input  logic [alpmf_pkg::RingAw-1:0]   waddr_i,
  input  logic [alpmf_pkg::RawW-1:0]     wdata_i,
  input  logic [alpmf_pkg::RingAw-1:0]   raddr_a_i,
  input  logic [alpmf_pkg::RingAw-1:0]   raddr_b_i,
  output logic [alpmf_pkg::RawW-1:0]     rdata_a_o,
  output logic [alpmf_pkg::RawW-1:0]     rdata_b_o
);

  logic [alpmf_pkg::RawW-1:0]       mem_q [alpmf_pkg::MAX_WINDOW];
  logic [alpmf_pkg::MAX_WINDOW-1:0] valid_q, valid_d;
  logic [alpmf_pkg::RawW-1:0]       rdata_a_q, rdata_b_q;
  logic                             rvld_a_q, rvld_b_q;

  // clear wins over old contents, the write of the same cycle wins over clear
  always_comb begin
    valid_d = clr_i ? '0 : valid_q;
    if (we_i) begin
      valid_d[waddr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvld_a_q <= 1'b0;
      rvld_b_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      rvld_a_q <= valid_q[raddr_a_i];
      rvld_b_q <= valid_q[raddr_b_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  // entries not written since reset or the last clear read as zero
  assign rdata_a_o = rvld_a_q ? rdata_a_q : '0;
  assign rdata_b_o = rvld_b_q ? rdata_b_q : '0;

endmodule

[design/alpmf_lowpass.sv]
// exponential low-pass with jump snap, one multiply stage and one add stage
module alpmf_lowpass (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  alpmf_pkg::filt_req_t          req_i,
  input  logic [alpmf_pkg::AlphaW-1:0]  alpha_i,
  input  logic [alpmf_pkg::ThrW-1:0]    thr_i,
  output alpmf_pkg::filt_rsp_t          rsp_o
);

  localparam int ProdW = (alpmf_pkg::AlphaFrac + 3) + (alpmf_pkg::OutW + 1);

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_ADD} lstate_e;

  lstate_e                         state_q;
  logic [alpmf_pkg::OutW-1:0]      avg_q, avg_d;
  alpmf_pkg::filt_rsp_t            rsp_q;
  logic [alpmf_pkg::RawW-1:0]      raw_q;
  logic signed [ProdW-1:0]         prod_q, prod_d;
  logic                            snap_q, snap_d;

  logic [alpmf_pkg::OutW-1:0]      samp;
  logic [alpmf_pkg::AlphaFrac:0]   a_sat;
  logic signed [alpmf_pkg::AlphaFrac+2:0] a_s;
  logic signed [alpmf_pkg::OutW:0] diff_s;
  logic [alpmf_pkg::OutW:0]        mag;
  logic signed [ProdW-1:0]         sum;

  always_comb begin
    samp   = alpmf_pkg::to_q12(raw_q);
    a_sat  = (alpha_i > alpmf_pkg::AlphaOne) ? alpmf_pkg::AlphaOne : alpha_i;
    a_s    = $signed({2'b00, a_sat});
    diff_s = $signed({1'b0, samp}) - $signed({1'b0, avg_q});
    mag    = diff_s[alpmf_pkg::OutW] ? (alpmf_pkg::OutW+1)'(-diff_s)
                                     : (alpmf_pkg::OutW+1)'(diff_s);
    snap_d = mag > {1'b0, thr_i, {alpmf_pkg::FracW{1'b0}}};
    prod_d = a_s * diff_s;
    // avg * one + alpha * (sample - avg) + half, then drop the fraction
    sum    = $signed({{(ProdW-alpmf_pkg::OutW-alpmf_pkg::AlphaFrac){1'b0}}, avg_q,
                      {alpmf_pkg::AlphaFrac{1'b0}}})
           + prod_q
           + $signed(ProdW'(1) << (alpmf_pkg::AlphaFrac - 1));
    avg_d  = snap_q ? samp
                    : sum[alpmf_pkg::OutW+alpmf_pkg::AlphaFrac-1:alpmf_pkg::AlphaFrac];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      avg_q   <= '0;
      rsp_q   <= '0;
    end else begin
      rsp_q.done <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          state_q <= L_ADD;
        end
        L_ADD: begin
          avg_q       <= avg_d;
          rsp_q.done  <= 1'b1;
          rsp_q.value <= avg_d;
          state_q     <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      raw_q <= req_i.raw;
    end
    if (state_q == L_MUL) begin
      prod_q <= prod_d;
      snap_q <= snap_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

[design/alpmf_median.sv]
// sliding median: ring update and rank-count selection over the ring memory
module alpmf_median (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  alpmf_pkg::filt_req_t         req_i,
  input  logic [alpmf_pkg::WinW-1:0]   win_i,
  output alpmf_pkg::filt_rsp_t         rsp_o
);

  localparam int Aw = alpmf_pkg::RingAw;
  localparam int Ww = alpmf_pkg::WinW;

  typedef enum logic {M_IDLE, M_RUN} mstate_e;

  mstate_e              state_q;
  logic [Ww-1:0]        tracked_q;
  logic [Aw-1:0]        pos_q;
  logic [Aw-1:0]        i_q, j_q;
  logic                 iss_q, cmp_vld_q, cmp_last_q;
  logic [Ww-1:0]        lt_q, le_q;
  alpmf_pkg::filt_rsp_t rsp_q;

  logic                      win_chg, win_big, win_zero, store, ring_clr;
  logic [Aw-1:0]             wpos, pos_next;
  logic [Ww-1:0]             wpos_inc, k, lt_f, le_f;
  logic                      last_j, last_i, found;
  logic [alpmf_pkg::RawW-1:0] rd_a, rd_b;

  always_comb begin
    win_zero = win_i == '0;
    win_chg  = win_i != tracked_q;
    win_big  = win_i > Ww'(alpmf_pkg::MAX_WINDOW);
    wpos     = (win_chg || (Ww'(pos_q) >= win_i)) ? '0 : pos_q;
    wpos_inc = Ww'(wpos) + Ww'(1);
    pos_next = (wpos_inc == win_i) ? '0 : wpos_inc[Aw-1:0];
    store    = req_i.start && !win_zero && !win_big;
    ring_clr = req_i.start && !win_zero && win_chg;
    last_j   = Ww'(j_q) == (tracked_q - Ww'(1));
    last_i   = Ww'(i_q) == (tracked_q - Ww'(1));
    k        = {1'b0, tracked_q[Ww-1:1]};
    lt_f     = lt_q + Ww'(rd_b < rd_a);
    le_f     = le_q + Ww'(rd_b <= rd_a);
    // candidate a is the median when rank k falls in its run of equal values
    found    = cmp_vld_q && cmp_last_q && (lt_f <= k) && (k < le_f);
  end

  alpmf_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (ring_clr),
    .we_i      (store),
    .waddr_i   (wpos),
    .wdata_i   (req_i.raw),
    .raddr_a_i (i_q),
    .raddr_b_i (j_q),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= M_IDLE;
      tracked_q  <= '0;
      pos_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      iss_q      <= 1'b0;
      cmp_vld_q  <= 1'b0;
      cmp_last_q <= 1'b0;
      lt_q       <= '0;
      le_q       <= '0;
      rsp_q      <= '0;
    end else begin
      rsp_q.done <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            if (win_zero) begin
              rsp_q.done  <= 1'b1;
              rsp_q.value <= alpmf_pkg::to_q12(req_i.raw);
            end else begin
              if (win_chg) begin
                tracked_q <= win_i;
                pos_q     <= '0;
              end
              if (win_big) begin
                rsp_q.done  <= 1'b1;
                rsp_q.value <= alpmf_pkg::to_q12(req_i.raw);
              end else begin
                pos_q   <= pos_next;
                i_q     <= '0;
                j_q     <= '0;
                lt_q    <= '0;
                le_q    <= '0;
                iss_q   <= 1'b1;
                state_q <= M_RUN;
              end
            end
          end
        end
        M_RUN: begin
          // read issue: candidate i on port a, every j on port b
          cmp_vld_q  <= iss_q;
          cmp_last_q <= iss_q && last_j;
          if (iss_q) begin
            if (last_j) begin
              j_q <= '0;
              if (last_i) begin
                iss_q <= 1'b0;
              end else begin
                i_q <= i_q + Aw'(1);
              end
            end else begin
              j_q <= j_q + Aw'(1);
            end
          end
          // compare stage on the registered read data
          if (cmp_vld_q) begin
            if (cmp_last_q) begin
              lt_q <= '0;
              le_q <= '0;
            end else begin
              lt_q <= lt_f;
              le_q <= le_f;
            end
          end
          if (found) begin
            rsp_q.done  <= 1'b1;
            rsp_q.value <= alpmf_pkg::to_q12(rd_a);
            iss_q       <= 1'b0;
            cmp_vld_q   <= 1'b0;
            cmp_last_q  <= 1'b0;
            state_q     <= M_IDLE;
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign rsp_o = rsp_q;

  a_iss_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q |-> (Ww'(i_q) < tracked_q) && (Ww'(j_q) < tracked_q))
    else $error("median read index outside the window");

  a_cmp_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> state_q == M_RUN)
    else $error("compare stage active outside a selection");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == M_IDLE && !iss_q)
    else $error("median started while busy");

  a_last_row_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmp_vld_q && cmp_last_q && !iss_q) |-> found)
    else $error("no median found after the last candidate");

endmodule

[design/angle_lowpass_median_filter.sv]
// top level of the angle filter: registers, mode dispatch and output register
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata[11:0] raw_angle, [15:12] zero
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata[23:0] filtered_angle
// cfg       in   cfg_we_i (no wait)             cfg_idx_i register, cfg_wdata_i value
//
// results pass res_q, then the output register, before m_axis_tvalid; pass-through
//   (mode 0, mode 3) loads res_q directly, median mode with window 0 or above MAX_WINDOW
//   via the median response register, low-pass via its 18x25 multiply and add states
// median: rank-count sweep reading the ring memory on two ports, one compare per cycle
// s_axis_tready returns the cycle after the result is loaded into the output register
// reset clears FSM and output registers, average, ring valid bits; no clearing pass
// a waiting result sits in the output register while the next transaction is taken
module angle_lowpass_median_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [11:0] raw_angle
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // [23:0] filtered_angle
  input  logic                            cfg_we_i,
  input  logic [alpmf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [alpmf_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_RESULT} state_e;

  // configuration registers
  logic [alpmf_pkg::ModeW-1:0]  mode_q;
  logic [alpmf_pkg::AlphaW-1:0] alpha_q;
  logic [alpmf_pkg::WinW-1:0]   win_q;
  logic [alpmf_pkg::ThrW-1:0]   thr_q;

  state_e                       state_q;
  logic [alpmf_pkg::OutW-1:0]   res_q;
  logic                         out_vld_q;
  logic [alpmf_pkg::OutW-1:0]   out_data_q;

  logic                         in_xfer;
  logic [alpmf_pkg::RawW-1:0]   raw;
  alpmf_pkg::filt_req_t         lp_req, med_req;
  alpmf_pkg::filt_rsp_t         lp_rsp, med_rsp;

  // register writes take effect at once; writes belong between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= alpmf_pkg::ModePass;
      alpha_q <= alpmf_pkg::AlphaRst;
      win_q   <= alpmf_pkg::WinRst;
      thr_q   <= alpmf_pkg::ThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        alpmf_pkg::CfgMode:   mode_q  <= cfg_wdata_i[alpmf_pkg::ModeW-1:0];
        alpmf_pkg::CfgAlpha:  alpha_q <= cfg_wdata_i[alpmf_pkg::AlphaW-1:0];
        alpmf_pkg::CfgWindow: win_q   <= cfg_wdata_i[alpmf_pkg::WinW-1:0];
        alpmf_pkg::CfgThresh: thr_q   <= cfg_wdata_i[alpmf_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign raw           = s_axis_tdata[alpmf_pkg::RawW-1:0];

  // only the selected filter sees the sample, the other keeps its state
  assign lp_req.start  = in_xfer && (mode_q == alpmf_pkg::ModeLowpass);
  assign lp_req.raw    = raw;
  assign med_req.start = in_xfer && (mode_q == alpmf_pkg::ModeMedian);
  assign med_req.raw   = raw;

  alpmf_lowpass u_lowpass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (lp_req),
    .alpha_i (alpha_q),
    .thr_i   (thr_q),
    .rsp_o   (lp_rsp)
  );

  alpmf_median u_median (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (med_req),
    .win_i  (win_q),
    .rsp_o  (med_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      res_q      <= '0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      // output slot drains on a master-side transaction
      if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            case (mode_q) inside
              alpmf_pkg::ModeLowpass,
              alpmf_pkg::ModeMedian: state_q <= S_WAIT;
              default: begin
                // pass-through and the unused mode code
                res_q   <= alpmf_pkg::to_q12(raw);
                state_q <= S_RESULT;
              end
            endcase
          end
        end
        S_WAIT: begin
          if (lp_rsp.done) begin
            res_q   <= lp_rsp.value;
            state_q <= S_RESULT;
          end else if (med_rsp.done) begin
            res_q   <= med_rsp.value;
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_vld_q || m_axis_tready) begin
            out_vld_q  <= 1'b1;
            out_data_q <= res_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_rsp_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lp_rsp.done && med_rsp.done))
    else $error("both filters answered in one cycle");

  a_rsp_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lp_rsp.done || med_rsp.done) |-> state_q == S_WAIT)
    else $error("filter answer while no sample is outstanding");

  a_pass_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && mode_q != alpmf_pkg::ModeLowpass && mode_q != alpmf_pkg::ModeMedian)
      |=> state_q == S_RESULT && res_q == alpmf_pkg::to_q12($past(raw)))
    else $error("pass-through sample not taken straight to the result");

endmodule

[verif/tb_angle_lowpass_median_filter.sv]
// self-checking testbench of the angle low-pass / median filter
module tb_angle_lowpass_median_filter;
  timeunit 1ns;
  timeprecision 1ps;

  // mode 3 has no name in the package, the block treats it as pass-through
  localparam logic [alpmf_pkg::ModeW-1:0] ModeUnused = 2'd3;
  localparam logic [16:0]                 Q15One     = 17'd32768;

  localparam int RandomItems = 925;
  localparam int LongHold    = 1500;   // receiver hold-off while the sender keeps pushing
  localparam int WatchLimit  = 20000;  // cycles without any transaction
  localparam int DrainCycles = 400;    // above the slowest median latency
  localparam int MaxReports  = 10;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [15:0]                    s_axis_tdata;  // [11:0] raw_angle, [15:12] zero
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [23:0]                    m_axis_tdata;  // [23:0] filtered_angle
  logic                           cfg_we_i;
  logic [alpmf_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [alpmf_pkg::CfgDataW-1:0] cfg_wdata_i;

  angle_lowpass_median_filter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shadow of the block: register copies and filter state
  // ---------------------------------------------------------------------------
  logic [alpmf_pkg::ModeW-1:0]  mode_r;
  logic [alpmf_pkg::AlphaW-1:0] alpha_r;
  logic [alpmf_pkg::WinW-1:0]   win_r;
  logic [alpmf_pkg::ThrW-1:0]   thr_r;
  logic [alpmf_pkg::OutW-1:0]   avg_r;                          // low-pass state, Q12.12
  logic [alpmf_pkg::RawW-1:0]   ring_r [alpmf_pkg::MAX_WINDOW]; // last raw samples
  int                           ring_pos;                       // next slot to write
  logic [alpmf_pkg::WinW-1:0]   ring_win;  // window the ring was filled for, 0 = none

  logic [alpmf_pkg::OutW-1:0]   pending_angles [$];  // filtered angles still owed
  int                           mismatch_cnt = 0;
  int                           idle_cycles  = 0;

  // pacing knobs of the sender and the receiver process
  bit                tx_steady   = 1'b0;
  bit                rx_steady   = 1'b0;
  bit                rx_hold_req = 1'b0;

  // filtered angle for one accepted raw sample, updating the shadow state
  function automatic logic [alpmf_pkg::OutW-1:0] filter_angle(
      input logic [alpmf_pkg::RawW-1:0] raw);
    logic [alpmf_pkg::OutW-1:0] s;
    logic [alpmf_pkg::OutW-1:0] diff;
    logic [16:0]                a;
    logic [63:0]                acc;
    logic [alpmf_pkg::RawW-1:0] sorted [alpmf_pkg::MAX_WINDOW];
    logic [alpmf_pkg::RawW-1:0] v;
    int                         j;
    int                         w;
    s = {raw, {alpmf_pkg::FracW{1'b0}}};
    case (mode_r)
      alpmf_pkg::ModeLowpass: begin
        diff = (s > avg_r) ? s - avg_r : avg_r - s;
        if (diff > {thr_r, {alpmf_pkg::FracW{1'b0}}}) begin
          // large jump: snap to the sample
          avg_r = s;
        end else begin
          // alpha above one saturates; rounding is half up
          a   = (17'(alpha_r) > Q15One) ? Q15One : 17'(alpha_r);
          acc = 64'(a) * 64'(s) + 64'(Q15One - a) * 64'(avg_r) + 64'(Q15One >> 1);
          avg_r = alpmf_pkg::OutW'(acc >> alpmf_pkg::AlphaFrac);
        end
        return avg_r;
      end
      alpmf_pkg::ModeMedian: begin
        w = int'(win_r);
        if (w == 0) return s;
        if (win_r != ring_win) begin
          foreach (ring_r[i]) ring_r[i] = '0;
          ring_pos = 0;
          ring_win = win_r;
        end
        // oversized window: change check ran, nothing stored
        if (w > alpmf_pkg::MAX_WINDOW) return s;
        if (ring_pos >= w) ring_pos = 0;
        ring_r[ring_pos] = raw;
        ring_pos = (ring_pos + 1) % w;
        for (int i = 0; i < w; i++) begin
          v = ring_r[i];
          j = i;
          while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = v;
        end
        return {sorted[w/2], {alpmf_pkg::FracW{1'b0}}};
      end
      default: return s;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one register write per cycle; the caller drops the write enable afterwards
  task automatic set_reg(input logic [alpmf_pkg::CfgIdxW-1:0]  idx,
                         input logic [alpmf_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      alpmf_pkg::CfgMode:   mode_r  = val[alpmf_pkg::ModeW-1:0];
      alpmf_pkg::CfgAlpha:  alpha_r = val[alpmf_pkg::AlphaW-1:0];
      alpmf_pkg::CfgWindow: win_r   = val[alpmf_pkg::WinW-1:0];
      alpmf_pkg::CfgThresh: thr_r   = val[alpmf_pkg::ThrW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // offer one raw sample, queue its filtered angle once the transaction happens
  task automatic send_angle(input logic [alpmf_pkg::RawW-1:0] raw, input bit known,
                            input logic [alpmf_pkg::OutW-1:0] want);
    int                         gap;
    logic [alpmf_pkg::OutW-1:0] predicted;
    gap = tx_steady ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = filter_angle(raw);
    pending_angles.push_back(known ? want : predicted);
  endtask

  // sender pauses until every owed angle has come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // directed script: register writes and samples, some with a hand-typed result
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                             is_cfg;
    logic [alpmf_pkg::CfgIdxW-1:0]  idx;
    logic [alpmf_pkg::CfgDataW-1:0] val;
    logic [alpmf_pkg::RawW-1:0]     raw;
    bit                             known;
    logic [alpmf_pkg::OutW-1:0]     want;
  } stim_row_t;

  stim_row_t script [$];

  function automatic stim_row_t cfg_row(input logic [alpmf_pkg::CfgIdxW-1:0]  idx,
                                        input logic [alpmf_pkg::CfgDataW-1:0] val);
    stim_row_t r;
    r.is_cfg = 1'b1; r.idx = idx; r.val = val;
    r.raw = '0; r.known = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t angle_row(input logic [alpmf_pkg::RawW-1:0] raw);
    stim_row_t r;
    r.is_cfg = 1'b0; r.idx = alpmf_pkg::CfgMode; r.val = '0;
    r.raw = raw; r.known = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [alpmf_pkg::RawW-1:0] raw,
                                          input logic [alpmf_pkg::OutW-1:0] want);
    stim_row_t r;
    r = angle_row(raw);
    r.known = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bit                          in_cfg;
    int                          phase;
    int                          batch;
    int                          sent;
    int                          pick;
    int                          delta;
    int                          t;
    logic [alpmf_pkg::ModeW-1:0] mode_val;
    logic [alpmf_pkg::RawW-1:0]  raw;
    logic [alpmf_pkg::RawW-1:0]  last_raw;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= alpmf_pkg::CfgMode;
    cfg_wdata_i   <= '0;

    // shadow state after reset
    mode_r  = alpmf_pkg::ModePass;
    alpha_r = alpmf_pkg::AlphaRst;
    win_r   = alpmf_pkg::WinRst;
    thr_r   = alpmf_pkg::ThrRst;
    avg_r   = '0;
    foreach (ring_r[i]) ring_r[i] = '0;
    ring_pos = 0;
    ring_win = '0;

    // pass-through after reset, extremes of the sample
    script.push_back(known_row(12'h000, 24'h000000));
    script.push_back(known_row(12'hFFF, 24'hFFF000));
    script.push_back(known_row(12'hA5A, 24'hA5A000));
    // unused mode passes through
    script.push_back(cfg_row(alpmf_pkg::CfgMode, alpmf_pkg::CfgDataW'(ModeUnused)));
    script.push_back(known_row(12'h5A5, 24'h5A5000));
    // low-pass: jumps beyond the threshold snap, alpha one tracks the sample
    script.push_back(cfg_row(alpmf_pkg::CfgMode,
                             alpmf_pkg::CfgDataW'(alpmf_pkg::ModeLowpass)));
    script.push_back(known_row(12'hFFF, 24'hFFF000));
    script.push_back(known_row(12'h000, 24'h000000));
    script.push_back(known_row(12'd100, 24'h064000));
    // alpha zero holds the average
    script.push_back(cfg_row(alpmf_pkg::CfgAlpha, 16'd0));
    script.push_back(known_row(12'd200, 24'h064000));
    // alpha above one saturates to one
    script.push_back(cfg_row(alpmf_pkg::CfgAlpha, 16'hFFFF));
    script.push_back(known_row(12'd300, 24'h12C000));
    script.push_back(cfg_row(alpmf_pkg::CfgAlpha, 16'd16384));
    script.push_back(angle_row(12'd400));
    // zero threshold: any difference snaps, no difference averages
    script.push_back(cfg_row(alpmf_pkg::CfgThresh, 16'd0));
    script.push_back(known_row(12'd401, 24'h191000));
    script.push_back(known_row(12'd401, 24'h191000));
    script.push_back(cfg_row(alpmf_pkg::CfgThresh, 16'd4095));
    script.push_back(angle_row(12'd0));
    // median: first use clears the ring, window changes clear it again
    script.push_back(cfg_row(alpmf_pkg::CfgMode,
                             alpmf_pkg::CfgDataW'(alpmf_pkg::ModeMedian)));
    script.push_back(known_row(12'd7, 24'h007000));
    script.push_back(cfg_row(alpmf_pkg::CfgWindow, 16'd3));
    script.push_back(known_row(12'hFFF, 24'h000000));
    script.push_back(known_row(12'hFFF, 24'hFFF000));
    script.push_back(angle_row(12'd5));
    script.push_back(cfg_row(alpmf_pkg::CfgWindow, 16'(alpmf_pkg::MAX_WINDOW)));
    script.push_back(known_row(12'hFFF, 24'h000000));
    script.push_back(angle_row(12'd1234));
    // zero window and oversized windows pass through
    script.push_back(cfg_row(alpmf_pkg::CfgWindow, 16'd0));
    script.push_back(known_row(12'd9, 24'h009000));
    script.push_back(cfg_row(alpmf_pkg::CfgWindow, 16'(alpmf_pkg::MAX_WINDOW + 1)));
    script.push_back(known_row(12'd10, 24'h00A000));
    script.push_back(cfg_row(alpmf_pkg::CfgWindow, 16'd63));
    script.push_back(known_row(12'd11, 24'h00B000));
    script.push_back(cfg_row(alpmf_pkg::CfgWindow, 16'd3));
    script.push_back(known_row(12'hFFF, 24'h000000));
    // low-pass state survived the median detour
    script.push_back(cfg_row(alpmf_pkg::CfgMode,
                             alpmf_pkg::CfgDataW'(alpmf_pkg::ModeLowpass)));
    script.push_back(angle_row(12'd2000));
    script.push_back(cfg_row(alpmf_pkg::CfgMode,
                             alpmf_pkg::CfgDataW'(alpmf_pkg::ModePass)));
    script.push_back(known_row(12'h000, 24'h000000));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part: writes only once the block has drained
    in_cfg = 1'b0;
    foreach (script[n]) begin
      if (script[n].is_cfg) begin
        if (!in_cfg) wait_idle();
        in_cfg = 1'b1;
        set_reg(script[n].idx, script[n].val);
      end else begin
        if (in_cfg) cfg_we_i <= 1'b0;
        in_cfg = 1'b0;
        send_angle(script[n].raw, script[n].known, script[n].want);
      end
    end

    // random part: phases of fresh settings, each followed by a full drain
    last_raw = '0;
    sent     = 0;
    phase    = 0;
    while (sent < RandomItems) begin
      wait_idle();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        // back-pressure burst: receiver stalls for a long stretch, sender keeps going
        set_reg(alpmf_pkg::CfgMode, alpmf_pkg::CfgDataW'(alpmf_pkg::ModePass));
        tx_steady   = 1'b1;
        rx_hold_req = 1'b1;
        batch       = 30;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0)     mode_val = $urandom_range(0, 1) ? ModeUnused : alpmf_pkg::ModePass;
        else if (pick < 5) mode_val = alpmf_pkg::ModeLowpass;
        else               mode_val = alpmf_pkg::ModeMedian;
        set_reg(alpmf_pkg::CfgMode, alpmf_pkg::CfgDataW'(mode_val));
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 4))
            0:       set_reg(alpmf_pkg::CfgAlpha, 16'd0);
            1:       set_reg(alpmf_pkg::CfgAlpha, 16'd32768);
            2:       set_reg(alpmf_pkg::CfgAlpha, 16'hFFFF);
            3:       set_reg(alpmf_pkg::CfgAlpha, 16'($urandom_range(0, 65535)));
            default: set_reg(alpmf_pkg::CfgAlpha, 16'($urandom_range(1, 32767)));
          endcase
        end
        // window kept unchanged half the time so the ring carries over
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 19))
            0:       set_reg(alpmf_pkg::CfgWindow, 16'd0);
            1:       set_reg(alpmf_pkg::CfgWindow,
                             16'($urandom_range(alpmf_pkg::MAX_WINDOW + 1, 63)));
            2, 3:    set_reg(alpmf_pkg::CfgWindow, 16'(alpmf_pkg::MAX_WINDOW));
            4, 5, 6: set_reg(alpmf_pkg::CfgWindow,
                             16'($urandom_range(8, alpmf_pkg::MAX_WINDOW - 1)));
            default: set_reg(alpmf_pkg::CfgWindow, 16'($urandom_range(1, 7)));
          endcase
        end
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 5))
            0:       set_reg(alpmf_pkg::CfgThresh, 16'd0);
            1:       set_reg(alpmf_pkg::CfgThresh, 16'd4095);
            2:       set_reg(alpmf_pkg::CfgThresh, 16'($urandom_range(0, 64)));
            default: set_reg(alpmf_pkg::CfgThresh, 16'($urandom_range(0, 4095)));
          endcase
        end
        batch = $urandom_range(4, 40);
      end
      cfg_we_i <= 1'b0;

      for (int k = 0; k < batch; k++) begin
        case ($urandom_range(0, 9))
          0:       raw = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          1, 2, 3: raw = 12'($urandom_range(0, 4095));
          default: begin
            // slow drift keeps the low-pass mostly below the snap threshold
            delta = int'($urandom_range(0, 128)) - 64;
            t     = int'(last_raw) + delta;
            if (t < 0)    t = 0;
            if (t > 4095) t = 4095;
            raw = 12'(t);
          end
        endcase
        last_raw = raw;
        send_angle(raw, 1'b0, '0);
      end
      sent += batch;
      phase++;
    end

    // drain, then give stray results a chance to show up
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls per result, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : rx_driver
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        gap         = LongHold;
        rx_hold_req = 1'b0;
      end else begin
        gap = rx_steady ? 0 : int'($urandom_range(0, 16));
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // ---------------------------------------------------------------------------
  // result check: each output transaction against the oldest owed angle
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : angle_check
    logic [alpmf_pkg::OutW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_angles.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports)
          $display("%0t: unexpected result %06h", $realtime, m_axis_tdata);
      end else begin
        want = pending_angles.pop_front();
        if (m_axis_tdata !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("%0t: filtered_angle expected %06h got %06h",
                     $realtime, want, m_axis_tdata);
        end
      end
    end
  end

  // watchdog: too long without any transaction on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
